// ----- rtl/mlcfm_pkg.sv -----
`default_nettype none

package mlcfm_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_CHIPS_DEF    = 4;
    localparam int SETTLE_COUNT_DEF = 4;

    // Hard limit on chips addressable by the 2-bit chip field
    localparam int CHIP_CAP = 4;

    localparam int RAW_W    = 28;
    localparam int READ_W   = 24;
    localparam int WORD_W   = 32;
    localparam int SUM_W    = 26;
    localparam int SETTLE_W = 3;
    localparam int CNT_W    = 3;
    localparam int GAIN_W   = 3;
    localparam int SLOT_W   = 2;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic OP_RESTART = 1'b0;
    localparam logic OP_FRAME   = 1'b1;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_DESYNC = 2'd1;
    localparam logic [1:0] ERR_LATE   = 2'd2;

    localparam logic [1:0] REG_CHIP_COUNT   = 2'd0;
    localparam logic [1:0] REG_GAIN_SELECT  = 2'd1;
    localparam logic [1:0] REG_PROBE_ENABLE = 2'd2;

    localparam logic [WORD_W-1:0] WORD_DESYNC = 32'h8000_0000;
    localparam logic [WORD_W-1:0] WORD_LATE   = 32'h4000_0000;
    localparam logic [WORD_W-1:0] WORD_BAD    = 32'h2000_0000;
    localparam logic [READ_W-1:0] READ_ALL_ONES = 24'hFF_FFFF;

    typedef struct packed {
        logic [CNT_W-1:0]  chip_count;
        logic [GAIN_W-1:0] gain_select;
        logic              probe_enable;
    } cfg_t;

    // Control half of a snapshot handed from the frame stage to the emitter
    typedef struct packed {
        logic             load;
        logic [1:0]       err;
        logic [CNT_W-1:0] n;
        logic             probe;
    } snap_ctl_t;

    function automatic logic [CNT_W-1:0] clamp_chips(input logic [CNT_W-1:0] cnt,
                                                     input int cap);
        logic [CNT_W-1:0] r;
        r = cnt;
        if (cnt == '0) begin
            r = CNT_W'(1);
        end else if (int'(cnt) > cap) begin
            r = CNT_W'(cap);
        end
        return r;
    endfunction

    function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
        logic [GAIN_W-1:0] r;
        r = g;
        if (g == '0) begin
            r = GAIN_W'(1);
        end else if (g > GAIN_W'(4)) begin
            r = GAIN_W'(4);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mlcfm_cfg_regs.sv -----
`default_nettype none

module mlcfm_cfg_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mlcfm_pkg::ADDR_W-1:0] paddr,
    input  logic [mlcfm_pkg::DATA_W-1:0] pwdata,
    output logic [mlcfm_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    output mlcfm_pkg::cfg_t              cfg
);
    import mlcfm_pkg::*;

    cfg_t       cfg_reg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        unique case (reg_idx)
            REG_CHIP_COUNT:   prdata = DATA_W'(cfg_reg.chip_count);
            REG_GAIN_SELECT:  prdata = DATA_W'(cfg_reg.gain_select);
            REG_PROBE_ENABLE: prdata = DATA_W'(cfg_reg.probe_enable);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.chip_count   <= CNT_W'(1);
            cfg_reg.gain_select  <= GAIN_W'(1);
            cfg_reg.probe_enable <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CHIP_COUNT:   cfg_reg.chip_count   <= pwdata[CNT_W-1:0];
                REG_GAIN_SELECT:  cfg_reg.gain_select  <= pwdata[GAIN_W-1:0];
                REG_PROBE_ENABLE: cfg_reg.probe_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mlcfm_frame_proc.sv -----
`default_nettype none

module mlcfm_frame_proc #(
    parameter int NCHIP        = mlcfm_pkg::MAX_CHIPS_DEF,
    parameter int SETTLE_COUNT = mlcfm_pkg::SETTLE_COUNT_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  mlcfm_pkg::cfg_t                               cfg,
    input  logic                                          s_valid,
    output logic                                          s_ready,
    input  logic                                          s_op,
    input  logic [mlcfm_pkg::SLOT_W-1:0]                  s_chip,
    input  logic [mlcfm_pkg::RAW_W-1:0]                   s_raw_frame,
    input  logic                                          s_frame_overrun,
    input  logic                                          s_pass_end,
    input  logic                                          snap_free,
    output mlcfm_pkg::snap_ctl_t                          snap_ctl,
    output logic [NCHIP-1:0]                              snap_bad,
    output logic [NCHIP-1:0][mlcfm_pkg::READ_W-1:0]       snap_reading
);
    import mlcfm_pkg::*;

    // input register
    logic              in_vld_reg;
    logic              op_reg;
    logic [SLOT_W-1:0] chip_reg;
    logic [RAW_W-1:0]  raw_reg;
    logic              late_reg;
    logic              pend_reg;

    // held state
    logic [NCHIP-1:0][READ_W-1:0]   held_reg,   held_next;
    logic [NCHIP-1:0]               bad_reg,    bad_next;
    logic [NCHIP-1:0][SETTLE_W-1:0] settle_reg, settle_next;
    logic [1:0]                     err_reg,    err_next;
    logic [NCHIP-1:0]               seen_reg,   seen_next;
    logic                           prim_reg,   prim_next;

    logic [CNT_W-1:0]  n;
    logic [GAIN_W-1:0] g;
    logic              trailer_ok;
    logic [READ_W-1:0] reading;
    logic              in_use;
    logic              all_seen;
    logic              emit;
    logic              fire;

    assign n = clamp_chips(cfg.chip_count, NCHIP);
    assign g = clamp_gain(cfg.gain_select);

    always_comb begin
        unique case (g)
            GAIN_W'(1): begin
                trailer_ok = raw_reg[0];
                reading    = raw_reg[24:1];
            end
            GAIN_W'(2): begin
                trailer_ok = &raw_reg[1:0];
                reading    = raw_reg[25:2];
            end
            GAIN_W'(3): begin
                trailer_ok = &raw_reg[2:0];
                reading    = raw_reg[26:3];
            end
            default: begin
                trailer_ok = &raw_reg[3:0];
                reading    = raw_reg[27:4];
            end
        endcase
    end

    assign in_use = ({1'b0, chip_reg} < n);

    always_comb begin
        held_next   = held_reg;
        bad_next    = bad_reg;
        settle_next = settle_reg;
        err_next    = err_reg;
        seen_next   = seen_reg;
        prim_next   = prim_reg;
        emit        = 1'b0;
        all_seen    = 1'b1;

        if (op_reg == OP_RESTART) begin
            bad_next  = '0;
            err_next  = ERR_NONE;
            seen_next = '0;
            prim_next = 1'b0;
            for (int i = 0; i < NCHIP; i++) begin
                settle_next[i] = SETTLE_W'(SETTLE_COUNT);
            end
        end else begin
            for (int i = 0; i < NCHIP; i++) begin
                if (in_use && chip_reg == SLOT_W'(i)) begin
                    if (settle_reg[i] != '0) begin
                        settle_next[i] = settle_reg[i] - SETTLE_W'(1);
                    end else if (!trailer_ok) begin
                        err_next = ERR_DESYNC;
                    end else if (reading == READ_ALL_ONES) begin
                        bad_next[i] = 1'b1;
                    end else if (late_reg) begin
                        err_next = ERR_LATE;
                    end else begin
                        bad_next[i]  = 1'b0;
                        held_next[i] = reading;
                        seen_next[i] = 1'b1;
                    end
                end
            end
            if (in_use && chip_reg == '0) begin
                prim_next = 1'b1;
            end
            for (int i = 0; i < NCHIP; i++) begin
                if (CNT_W'(i) < n && !seen_next[i]) begin
                    all_seen = 1'b0;
                end
            end
            if (pend_reg) begin
                emit      = prim_next && (err_next != ERR_NONE || all_seen);
                prim_next = 1'b0;
            end
        end
    end

    assign fire    = in_vld_reg && (!emit || snap_free);
    assign s_ready = !in_vld_reg || fire;

    assign snap_ctl.load  = fire && emit;
    assign snap_ctl.err   = err_next;
    assign snap_ctl.n     = n;
    assign snap_ctl.probe = cfg.probe_enable;
    assign snap_bad       = bad_next;
    assign snap_reading   = held_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            op_reg   <= s_op;
            chip_reg <= s_chip;
            raw_reg  <= s_raw_frame;
            late_reg <= s_frame_overrun;
            pend_reg <= s_pass_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bad_reg    <= '0;
            settle_reg <= '0;
            err_reg    <= ERR_NONE;
            seen_reg   <= '0;
            prim_reg   <= 1'b0;
        end else if (fire) begin
            bad_reg    <= bad_next;
            settle_reg <= settle_next;
            err_reg    <= err_next;
            seen_reg   <= seen_next;
            prim_reg   <= prim_next;
        end
        if (fire) begin
            held_reg <= held_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mlcfm_emitter.sv -----
`default_nettype none

module mlcfm_emitter #(
    parameter int NCHIP = mlcfm_pkg::MAX_CHIPS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  mlcfm_pkg::snap_ctl_t                    snap_ctl,
    input  logic [NCHIP-1:0]                        snap_bad,
    input  logic [NCHIP-1:0][mlcfm_pkg::READ_W-1:0] snap_reading,
    output logic                                    snap_free,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [mlcfm_pkg::SLOT_W-1:0]            m_slot,
    output logic [mlcfm_pkg::WORD_W-1:0]            m_word,
    output logic signed [mlcfm_pkg::SUM_W-1:0]      m_load_sum,
    output logic                                    m_sum_valid,
    output logic                                    m_last
);
    import mlcfm_pkg::*;

    // snapshot of one frame set
    logic                         sv_reg;
    logic [1:0]                   s_err_reg;
    logic [CNT_W-1:0]             s_n_reg;
    logic                         s_probe_reg;
    logic [NCHIP-1:0]             s_bad_reg;
    logic [NCHIP-1:0][READ_W-1:0] s_read_reg;
    logic [SLOT_W-1:0]            idx_reg;

    // output register
    logic                     m_valid_reg;
    logic [SLOT_W-1:0]        m_slot_reg;
    logic [WORD_W-1:0]        m_word_reg;
    logic signed [SUM_W-1:0]  m_sum_reg;
    logic                     m_sum_valid_reg;
    logic                     m_last_reg;

    logic                    out_free;
    logic                    last_idx;
    logic                    move;
    logic [READ_W-1:0]       sel_read;
    logic                    sel_bad;
    logic                    sum_ok;
    logic signed [SUM_W-1:0] sum;
    logic [WORD_W-1:0]       word;

    assign out_free  = !m_valid_reg || m_ready;
    assign last_idx  = (CNT_W'(idx_reg) + CNT_W'(1) == s_n_reg);
    assign move      = sv_reg && out_free;
    assign snap_free = !sv_reg || (out_free && last_idx);

    always_comb begin
        sel_read = s_read_reg[0];
        sel_bad  = s_bad_reg[0];
        for (int i = 1; i < NCHIP; i++) begin
            if (idx_reg == SLOT_W'(i)) begin
                sel_read = s_read_reg[i];
                sel_bad  = s_bad_reg[i];
            end
        end
    end

    assign sum_ok = (s_err_reg == ERR_NONE) && s_probe_reg;

    always_comb begin
        sum = '0;
        for (int i = 0; i < NCHIP; i++) begin
            if (CNT_W'(i) < s_n_reg) begin
                sum = sum + SUM_W'(signed'(s_read_reg[i]));
            end
        end
        if (!sum_ok) begin
            sum = '0;
        end
    end

    always_comb begin
        priority if (s_err_reg == ERR_DESYNC) begin
            word = WORD_DESYNC;
        end else if (s_err_reg == ERR_LATE) begin
            word = WORD_LATE;
        end else if (sel_bad) begin
            word = WORD_BAD;
        end else begin
            word = WORD_W'(signed'(sel_read));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg  <= 1'b0;
            idx_reg <= '0;
        end else if (snap_ctl.load) begin
            sv_reg  <= 1'b1;
            idx_reg <= '0;
        end else if (move && last_idx) begin
            sv_reg  <= 1'b0;
            idx_reg <= '0;
        end else if (move) begin
            idx_reg <= idx_reg + SLOT_W'(1);
        end
        if (snap_ctl.load) begin
            s_err_reg   <= snap_ctl.err;
            s_n_reg     <= snap_ctl.n;
            s_probe_reg <= snap_ctl.probe;
            s_bad_reg   <= snap_bad;
            s_read_reg  <= snap_reading;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (move) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (move) begin
            m_slot_reg      <= idx_reg;
            m_word_reg      <= word;
            m_sum_reg       <= sum;
            m_sum_valid_reg <= sum_ok;
            m_last_reg      <= last_idx;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_slot      = m_slot_reg;
    assign m_word      = m_word_reg;
    assign m_load_sum  = m_sum_reg;
    assign m_sum_valid = m_sum_valid_reg;
    assign m_last      = m_last_reg;

endmodule

`default_nettype wire

// ----- rtl/multi_loadcell_adc_frame_merger.sv -----
// Channel   | Direction | Beat carries                                        | Handshake
// ----------+-----------+-----------------------------------------------------+----------------
// s_        | in        | op, chip, raw_frame, frame_overrun, pass_end        | s_valid/s_ready
// m_        | out       | slot, word, load_sum, sum_valid, last               | m_valid/m_ready
// APB       | in/out    | chip_count (0x0), gain_select (0x4), probe_enable (0x8) | psel/penable
//
// Flow: an input beat is registered, then checked and folded into the chip state; a beat
//   that causes no words leaves room for the next beat every cycle.
// A beat that closes a pass and emits copies the state into a single snapshot buffer; the
//   snapshot drains one word per cycle through the output register while it is free, and
//   the next emitting beat can pass once the last of its chip_count words (1..4) moves.
// Reset (aresetn low, synchronous) clears errors, marks, settle counters, seen mask, pass
//   flag and the input, snapshot and output valid flags; held readings are not cleared.
// Stalls: m_ready low holds the output register; an emitting beat waits in the input
//   register while the snapshot still has words to drain, and s_ready drops only then.
`default_nettype none

module multi_loadcell_adc_frame_merger #(
    parameter int MAX_CHIPS    = mlcfm_pkg::MAX_CHIPS_DEF,
    parameter int SETTLE_COUNT = mlcfm_pkg::SETTLE_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input beats
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic [mlcfm_pkg::SLOT_W-1:0]      s_chip,
    input  logic [mlcfm_pkg::RAW_W-1:0]       s_raw_frame,
    input  logic                              s_frame_overrun,
    input  logic                              s_pass_end,
    // result beats
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mlcfm_pkg::SLOT_W-1:0]      m_slot,
    output logic [mlcfm_pkg::WORD_W-1:0]      m_word,
    output logic signed [mlcfm_pkg::SUM_W-1:0] m_load_sum,
    output logic                              m_sum_valid,
    output logic                              m_last,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mlcfm_pkg::ADDR_W-1:0]      paddr,
    input  logic [mlcfm_pkg::DATA_W-1:0]      pwdata,
    output logic [mlcfm_pkg::DATA_W-1:0]      prdata,
    output logic                              pready
);
    import mlcfm_pkg::*;

    // chips with storage: the chip field addresses at most four
    localparam int NCHIP = (MAX_CHIPS < CHIP_CAP) ? MAX_CHIPS : CHIP_CAP;

    cfg_t                         cfg;
    snap_ctl_t                    snap_ctl;
    logic [NCHIP-1:0]             snap_bad;
    logic [NCHIP-1:0][READ_W-1:0] snap_reading;
    logic                         snap_free;

    // configuration registers, to be written only while idle; the block does not enforce it
    mlcfm_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register, frame checks and chip state
    mlcfm_frame_proc #(
        .NCHIP        (NCHIP),
        .SETTLE_COUNT (SETTLE_COUNT)
    ) u_proc (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_chip          (s_chip),
        .s_raw_frame     (s_raw_frame),
        .s_frame_overrun (s_frame_overrun),
        .s_pass_end      (s_pass_end),
        .snap_free       (snap_free),
        .snap_ctl        (snap_ctl),
        .snap_bad        (snap_bad),
        .snap_reading    (snap_reading)
    );

    // snapshot buffer and output register, one word per beat
    mlcfm_emitter #(
        .NCHIP (NCHIP)
    ) u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .snap_ctl     (snap_ctl),
        .snap_bad     (snap_bad),
        .snap_reading (snap_reading),
        .snap_free    (snap_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_slot       (m_slot),
        .m_word       (m_word),
        .m_load_sum   (m_load_sum),
        .m_sum_valid  (m_sum_valid),
        .m_last       (m_last)
    );

endmodule

`default_nettype wire

// ----- rtl/mlcfm_checker.sv -----
`default_nettype none

module mlcfm_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic [mlcfm_pkg::WORD_W-1:0]      m_word,
    input wire logic signed [mlcfm_pkg::SUM_W-1:0] m_load_sum,
    input wire logic                              m_sum_valid
);
    import mlcfm_pkg::*;

    // stalled beat holds its word
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result beat changed under stall");

    // no summed reading without a valid flag
    a_sum_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_sum_valid |-> m_load_sum == '0)
        else $error("load_sum non-zero while sum_valid low");

    // with sum_valid set (no error latched, probe on) a word is a 24-bit reading or the bad-frame code
    a_word_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sum_valid |->
            (m_word[31:23] == '0) || (m_word[31:23] == '1) || (m_word == WORD_BAD))
        else $error("error code on a word with sum_valid set");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

endmodule

bind multi_loadcell_adc_frame_merger mlcfm_checker u_mlcfm_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_word      (m_word),
    .m_load_sum  (m_load_sum),
    .m_sum_valid (m_sum_valid)
);

`default_nettype wire
